FILE: hdl/positional_list_engine_core_assert.svh
// Assertion macros shared by the positional list engine RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef POSITIONAL_LIST_ENGINE_CORE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_CORE_ASSERT_SVH

// Check that is disabled while reset is asserted
`define PLE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also runs through reset
`define PLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/ple_pkg.sv
// Shared types and constants for the positional list engine.
// No dependencies; imported by ple_cell and positional_list_engine_core.
package ple_pkg;

    localparam int POS_W = 8;
    localparam int VAL_W = 32;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_INSERT   = 2'd0,
        REQ_GET      = 2'd1,
        REQ_DELETE   = 2'd2,
        REQ_RESERVED = 2'd3
    } t_req_kind;

    // Response status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    typedef struct packed {
        t_req_kind               req_type;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_req_item;

    typedef struct packed {
        t_status                 status;
        logic signed [VAL_W-1:0] read_value;
    } t_rsp_item;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic                    ins;   // insert at slot, later entries move up
        logic                    del;   // remove slot, later entries move down
        logic [POS_W-1:0]        slot;  // 0-based position
        logic signed [VAL_W-1:0] value;
    } t_cell_cmd;

endpackage

FILE: hdl/positional_list_engine_core.sv
// A result is registered and is offered in the cycle after its request transfer.
// Throughput: one request per cycle unless stalled; every cell shifts in the same cycle.
// Requests stall only while a result is held and the result side stalls.
// Reset clears the entry count and the result valid; entry contents are
// left undefined, as no position at or above the count is ever read.
module positional_list_engine_core import ple_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    output logic      o_req_stall,
    input  t_req_item i_req,
    output logic      o_rsp_valid,
    input  logic      i_rsp_stall,
    output t_rsp_item o_rsp
);

`include "positional_list_engine_core_assert.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic                    r_out_valid;
    t_rsp_item               r_out;
    t_rsp_item               n_out;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;

    logic                    w_accept;
    logic [POS_W-1:0]        w_slot;
    logic [CMP_W-1:0]        w_slot_x;
    logic [CMP_W-1:0]        w_count_x;
    logic                    w_full;
    logic                    w_ins_ok;
    logic                    w_del_ok;
    logic signed [VAL_W-1:0] w_rd;
    t_cell_cmd               w_cmd;

    logic signed [VAL_W-1:0] w_val   [CAPACITY];
    logic signed [VAL_W-1:0] w_left  [CAPACITY];
    logic signed [VAL_W-1:0] w_right [CAPACITY];

    // Handshake
    assign o_req_stall = r_out_valid & i_rsp_stall;
    assign w_accept    = i_req_valid & ~o_req_stall;
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // Position checks
    assign w_slot    = i_req.position - 1'b1;
    assign w_slot_x  = CMP_W'(w_slot);
    assign w_count_x = CMP_W'(r_count);
    assign w_full    = (r_count >= CNT_W'(CAPACITY));

    assign w_ins_ok = w_accept && (i_req.req_type == REQ_INSERT) && (i_req.position != '0)
                      && (w_slot_x <= w_count_x) && !w_full;
    assign w_del_ok = w_accept && (i_req.req_type == REQ_DELETE) && (i_req.position != '0)
                      && (w_slot_x < w_count_x);

    // Command to the chain
    always_comb begin
        w_cmd.ins   = w_ins_ok;
        w_cmd.del   = w_del_ok;
        w_cmd.slot  = w_slot;
        w_cmd.value = i_req.value;
    end

    // Chain of cells, each wired to its neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = w_val[g];
        end else begin : g_mid_l
            assign w_left[g] = w_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right[g] = w_val[g];
        end else begin : g_mid_r
            assign w_right[g] = w_val[g+1];
        end

        ple_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_value (w_val[g])
        );
    end

    // Read select at the requested slot
    always_comb begin
        w_rd = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (POS_W'(i) == w_slot) begin
                w_rd = w_val[i];
            end
        end
    end

    // Result and count update
    always_comb begin
        n_out.status     = ST_OK;
        n_out.read_value = '0;
        n_count          = r_count;
        if (i_req.req_type == REQ_RESERVED) begin
            n_out.status = ST_UNKNOWN;
        end else if (i_req.position == '0) begin
            n_out.status = ST_BAD_POS;
        end else if (i_req.req_type == REQ_INSERT) begin
            if (w_slot_x > w_count_x) begin
                n_out.status = ST_BAD_POS;
            end else if (w_full) begin
                n_out.status = ST_FULL;
            end
        end else if (w_slot_x >= w_count_x) begin
            n_out.status = ST_BAD_POS;
        end else begin
            n_out.read_value = w_rd;
        end
        if (w_ins_ok) begin
            n_count = r_count + 1'b1;
        end else if (w_del_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    // Checks
    `PLE_ASSERT_ALWAYS(a_rst_count, i_clk, !i_rst_n |=> r_count == '0, "count not cleared")
    `PLE_ASSERT(a_cnt_max, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY), "count over capacity")
    `PLE_ASSERT(a_ins_cnt, i_clk, i_rst_n, w_ins_ok |=> r_count == $past(r_count) + 1'b1, "insert count")
    `PLE_ASSERT(a_err_zero, i_clk, i_rst_n, (r_out_valid && r_out.status != ST_OK) |-> r_out.read_value == '0, "error value")

endmodule

FILE: hdl/ple_cell.sv
// One storage cell of the list chain: holds the entry at a fixed position.
// Depends on ple_pkg; instantiated in a row by positional_list_engine_core.
module ple_cell import ple_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic                    i_clk,
    input  t_cell_cmd               i_cmd,
    input  logic signed [VAL_W-1:0] i_left,
    input  logic signed [VAL_W-1:0] i_right,
    output logic signed [VAL_W-1:0] o_value
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] n_value;

    // Pick new value: load, take from lower neighbor, take from upper neighbor
    always_comb begin
        n_value = r_value;
        if (i_cmd.ins) begin
            if (i_cmd.slot == MY_POS) begin
                n_value = i_cmd.value;
            end else if (i_cmd.slot < MY_POS) begin
                n_value = i_left;
            end
        end else if (i_cmd.del && (i_cmd.slot <= MY_POS)) begin
            n_value = i_right;
        end
    end

    // Entry storage, undefined until written
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

FILE: tb/ple_checker.sv
// Scoreboard for positional_list_engine_core: keeps its own copy of the list,
// predicts a result for each request transfer, and checks result transfers in order.
// Depends on ple_pkg.
module ple_checker import ple_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    input  logic      i_req_stall,
    input  t_req_item i_req,
    input  logic      i_rsp_valid,
    input  logic      i_rsp_stall,
    input  t_rsp_item i_rsp,
    output int        o_errors,
    output int        o_pending,
    output int        o_checked
);

    // Shadow list; only slots below list_len are ever read
    logic signed [VAL_W-1:0] list_vals [CAPACITY];
    int unsigned             list_len;
    t_rsp_item               expected_rsp [$];

    // One line per mismatch, and count it
    task automatic report_mismatch(string what, logic signed [VAL_W-1:0] got,
                                   logic signed [VAL_W-1:0] want);
        $display("ple_checker: result %0d %s: got %0d, expected %0d",
                 o_checked, what, got, want);
        o_errors++;
    endtask

    // Apply one request to the shadow list and return the result it must give
    function automatic t_rsp_item apply_request(t_req_item rq);
        t_rsp_item   rsp;
        int unsigned slot;
        rsp.status     = ST_OK;
        rsp.read_value = '0;
        slot           = (rq.position == 0) ? 0 : rq.position - 1;
        if (rq.req_type == REQ_RESERVED) begin
            rsp.status = ST_UNKNOWN;
        end else if (rq.position == 0) begin
            rsp.status = ST_BAD_POS;
        end else if (rq.req_type == REQ_INSERT) begin
            // position is checked before fullness
            if (slot > list_len) begin
                rsp.status = ST_BAD_POS;
            end else if (list_len >= CAPACITY) begin
                rsp.status = ST_FULL;
            end else begin
                for (int k = list_len; k > slot; k--)
                    list_vals[k] = list_vals[k-1];
                list_vals[slot] = rq.value;
                list_len++;
            end
        end else if (slot >= list_len) begin
            rsp.status = ST_BAD_POS;
        end else begin
            rsp.read_value = list_vals[slot];
            if (rq.req_type == REQ_DELETE) begin
                for (int k = slot; k + 1 < list_len; k++)
                    list_vals[k] = list_vals[k+1];
                list_len--;
            end
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp_item want;
        if (!i_rst_n) begin
            list_len = 0;
            expected_rsp.delete();
            o_errors  = 0;
            o_checked = 0;
            o_pending <= 0;
        end else begin
            // request transfer: predict its result
            if (i_req_valid && !i_req_stall)
                expected_rsp.push_back(apply_request(i_req));
            // result transfer: compare with the oldest prediction
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_rsp.size() == 0) begin
                    report_mismatch("with nothing expected", i_rsp.read_value, '0);
                end else begin
                    want = expected_rsp.pop_front();
                    if (i_rsp.status !== want.status)
                        report_mismatch("status", i_rsp.status, want.status);
                    if (i_rsp.read_value !== want.read_value)
                        report_mismatch("read_value", i_rsp.read_value, want.read_value);
                end
                o_checked++;
            end
            o_pending <= expected_rsp.size();
        end
    end

endmodule

FILE: tb/tb.sv
// Testbench top for positional_list_engine_core: clock, reset, request stimulus
// with random idling, result-side stalls and the verdict.
// Depends on ple_pkg, ple_checker and the core RTL.
module tb;
    import ple_pkg::*;

    localparam int          CAPACITY     = 16;
    localparam int          RANDOM_ITEMS = 650;
    localparam int          HOLD_CYCLES  = 64;
    localparam int          DRAIN_CYCLES = 4;
    localparam int unsigned RUN_LIMIT    = 10_000_000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    t_req_item req_item  = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    t_rsp_item rsp_item;
    int        errors;
    int        pending;
    int        checked;

    // Stimulus bookkeeping: list length after every request sent so far
    int list_len   = 0;
    int sent       = 0;
    int full_hits  = 0;
    int empty_hits = 0;
    int quiet_left = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    positional_list_engine_core #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req_valid(req_valid),
        .o_req_stall(req_stall),
        .i_req      (req_item),
        .o_rsp_valid(rsp_valid),
        .i_rsp_stall(rsp_stall),
        .o_rsp      (rsp_item)
    );

    ple_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req_valid(req_valid),
        .i_req_stall(req_stall),
        .i_req      (req_item),
        .i_rsp_valid(rsp_valid),
        .i_rsp_stall(rsp_stall),
        .i_rsp      (rsp_item),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    // Random value, with the extremes and zero showing up often
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // Sender gap: mostly none or short, a few long, with runs of back-to-back items
    task automatic idle_req();
        int unsigned r;
        int unsigned gap;
        r   = $urandom_range(99);
        gap = 0;
        if (quiet_left > 0)
            quiet_left--;
        else if (r < 4)
            quiet_left = $urandom_range(40, 10);
        else if (r < 55)
            gap = 0;
        else if (r < 85)
            gap = $urandom_range(3, 1);
        else if (r < 97)
            gap = $urandom_range(10, 4);
        else
            gap = $urandom_range(40, 11);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Offer one request, hold it until the transfer, then idle
    task automatic send_req(t_req_kind kind, logic [POS_W-1:0] pos,
                            logic signed [VAL_W-1:0] val);
        t_req_item rq;
        rq.req_type = kind;
        rq.position = pos;
        rq.value    = val;
        req_valid <= 1'b1;
        req_item  <= rq;
        do @(posedge clk); while (req_stall);
        sent++;
        // follow the list length so positions can be aimed at the valid range
        if (kind == REQ_INSERT && pos >= 1 && pos <= list_len + 1) begin
            if (list_len == CAPACITY)
                full_hits++;
            else
                list_len++;
        end else if (kind == REQ_DELETE && pos >= 1 && pos <= list_len) begin
            list_len--;
            if (list_len == 0)
                empty_hits++;
        end
        idle_req();
    endtask

    // Result side: random stalls, free-running stretches, and a long hold now
    // and then so the block fills and pushes back on requests
    initial begin : rsp_side
        int unsigned r;
        int unsigned span;
        int unsigned rounds;
        rounds = 0;
        while (!rst_n) @(posedge clk);
        forever begin
            rounds++;
            if (rounds % 150 == 40) begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                r = $urandom_range(99);
                if (r < 55) begin
                    rsp_stall <= 1'b0;
                    span = $urandom_range(20, 1);
                end else if (r < 60) begin
                    rsp_stall <= 1'b0;
                    span = $urandom_range(80, 30);
                end else if (r < 90) begin
                    rsp_stall <= 1'b1;
                    span = $urandom_range(3, 1);
                end else if (r < 97) begin
                    rsp_stall <= 1'b1;
                    span = $urandom_range(12, 4);
                end else begin
                    rsp_stall <= 1'b1;
                    span = $urandom_range(40, 13);
                end
                repeat (span) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        t_req_kind   kind;
        int unsigned pick;
        int          top_pos;
        logic [POS_W-1:0] pos;
        bit          growing;
        growing = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reserved request, position zero, empty-list errors
        send_req(REQ_RESERVED, 1, 32'sd5);
        send_req(REQ_GET, 0, '0);
        send_req(REQ_GET, 1, '0);
        send_req(REQ_DELETE, 1, '0);
        send_req(REQ_INSERT, 2, 32'sd7);
        // insert at front, append and middle with extreme values
        send_req(REQ_INSERT, 1, 32'sh7fff_ffff);
        send_req(REQ_INSERT, 1, 32'sh8000_0000);
        send_req(REQ_INSERT, 3, '0);
        send_req(REQ_INSERT, 2, -1);
        // fill the list to capacity
        while (list_len < CAPACITY)
            send_req(REQ_INSERT, POS_W'($urandom_range(list_len + 1, 1)), pick_value());
        // full list: valid position is full, one past that is a bad position
        send_req(REQ_INSERT, CAPACITY + 1, 32'sd1);
        send_req(REQ_INSERT, CAPACITY + 2, 32'sd2);
        send_req(REQ_INSERT, 255, 32'sd3);
        send_req(REQ_GET, CAPACITY, '0);
        send_req(REQ_GET, CAPACITY + 1, '0);
        send_req(REQ_DELETE, CAPACITY, '0);
        send_req(REQ_DELETE, 1, '0);

        // Random: phases that grow and shrink the list, positions mostly in range
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(29) == 0)
                growing = !growing;
            pick = $urandom_range(99);
            if (pick < 2)
                kind = REQ_RESERVED;
            else if (pick < (growing ? 60 : 22))
                kind = REQ_INSERT;
            else if (pick < (growing ? 80 : 42))
                kind = REQ_GET;
            else
                kind = REQ_DELETE;
            top_pos = (kind == REQ_INSERT) ? list_len + 1 : list_len;
            pick    = $urandom_range(99);
            if (pick < 80 && top_pos > 0) begin
                pos = POS_W'($urandom_range(top_pos, 1));
            end else if (pick < 90) begin
                case ($urandom_range(3))
                    0:       pos = '0;
                    1:       pos = POS_W'(top_pos + 1);
                    2:       pos = POS_W'(1);
                    default: pos = POS_W'(top_pos);
                endcase
            end else begin
                pos = POS_W'($urandom_range(255));
            end
            send_req(kind, pos, pick_value());
        end
        req_valid <= 1'b0;

        // Drain: wait for every predicted result, then idle before the verdict
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("tb: %0d requests sent, %0d results checked, %0d mismatches",
                 sent, checked, errors);
        $display("tb: inserts refused on a full list %0d times, list emptied %0d times",
                 full_hits, empty_hits);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #(RUN_LIMIT);
        $display("tb: timeout with %0d results outstanding", pending);
        $display("tb: done, errors");
        $finish;
    end

endmodule
